@@ hdl/sle_pkg.sv @@
// sle_pkg: shared constants, codes and control structs of the sorted list engine
// no dependencies; imported by every module of the block

package sle_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int POS_W = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the accepted item
        logic search;  // register the compare results
        logic commit;  // update the store and the result register
    } t_dp_cmd;

endpackage

@@ hdl/sle_if.sv @@
// sle_if: valid/ready channel interfaces of the sorted list engine
// depends on sle_pkg for field widths

interface sle_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [sle_pkg::OP_W-1:0]             operation;
    logic signed [sle_pkg::VAL_W-1:0]     value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface sle_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [sle_pkg::ST_W-1:0]             status;
    logic [sle_pkg::POS_W-1:0]            position;
    logic [sle_pkg::POS_W-1:0]            count;

    modport source (output valid, output status, output position, output count, input ready);
    modport sink   (input valid, input status, input position, input count, output ready);
endinterface

@@ hdl/sle_dp.sv @@
// sle_dp: datapath of the sorted list engine: entry cells, count, parallel compare
// depends on sle_pkg; driven by sle_ctrl through t_dp_cmd

module sle_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sle_pkg::t_dp_cmd              i_cmd,
    input  logic [sle_pkg::OP_W-1:0]      i_operation,
    input  logic signed [sle_pkg::VAL_W-1:0] i_value,
    output logic [sle_pkg::ST_W-1:0]      o_status,
    output logic [sle_pkg::POS_W-1:0]     o_position,
    output logic [sle_pkg::POS_W-1:0]     o_count
);
    import sle_pkg::*;

    logic signed [VAL_W-1:0] r_entries [DEPTH];
    logic signed [VAL_W-1:0] n_entries [DEPTH];
    logic [CNT_W-1:0]        r_count, n_count;
    logic [OP_W-1:0]         r_op;
    logic signed [VAL_W-1:0] r_val;
    logic [CNT_W-1:0]        r_lb;
    logic                    r_hit;
    logic [ST_W-1:0]         r_status, n_status;
    logic [CNT_W-1:0]        r_pos, n_pos;

    logic [DEPTH-1:0]        lt_vec;
    logic [DEPTH-1:0]        eq_vec;
    logic [CNT_W-1:0]        lb;

    // compare every live cell against the operand at once
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            lt_vec[i] = (CNT_W'(i) < r_count) && (r_entries[i] < r_val);
            eq_vec[i] = (CNT_W'(i) < r_count) && (r_entries[i] == r_val);
        end
    end

    // list is sorted, so lt_vec is a prefix: lower bound is its first zero
    always_comb begin
        lb = CNT_W'(DEPTH);
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!lt_vec[i]) begin
                lb = CNT_W'(i);
            end
        end
    end

    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        n_status  = ST_OK;
        n_pos     = '0;
        unique case (r_op)
            OP_INSERT: begin
                if (r_count == CNT_W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    n_pos   = r_lb;
                    n_count = r_count + 1'b1;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CNT_W'(i) == r_lb) begin
                            n_entries[i] = r_val;
                        end else if (i > 0 && CNT_W'(i) > r_lb) begin
                            n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
                        end
                    end
                end
            end
            OP_REMOVE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (!r_hit) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    // first equal entry sits at the lower bound
                    n_pos   = r_lb;
                    n_count = r_count - 1'b1;
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (CNT_W'(i) >= r_lb) begin
                            n_entries[i] = r_entries[i + 1];
                        end
                    end
                end
            end
            OP_QUERY: begin
                n_pos = r_lb;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_val <= i_value;
        end
        if (i_cmd.search) begin
            r_lb  <= lb;
            r_hit <= |eq_vec;
        end
        if (i_cmd.commit) begin
            r_entries <= n_entries;
            r_status  <= n_status;
            r_pos     <= n_pos;
        end
    end

    assign o_status   = r_status;
    assign o_position = POS_W'(r_pos);
    assign o_count    = POS_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("stored count above depth");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |=> r_count == $past(r_count))
        else $error("count changed without a commit");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1
                          || r_count == $past(r_count) - 1'b1))
        else $error("count moved by more than one");

endmodule

@@ hdl/sle_ctrl.sv @@
// sle_ctrl: controller of the sorted list engine: sequencing and channel handshakes
// depends on sle_pkg; drives sle_dp through t_dp_cmd

module sle_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sle_pkg::t_dp_cmd  o_cmd
);
    import sle_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign o_in_ready = (r_state == S_IDLE);
    // result register can take a new result if empty or being drained
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd.load   = 1'b0;
        o_cmd.search = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.search = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_UPD)
        else $error("result appeared without an update step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !(r_out_valid && !i_out_ready))
        else $error("commit while a stalled result is held");

    a_search_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == S_CMP)
        else $error("accepted item not searched next cycle");

endmodule

@@ hdl/sorted_list_engine_top.sv @@
// sorted_list_engine_top: sorted store of signed values with insert, remove, query
// Use: items arrive on i_in (operation, value) and each gives one result on o_out
// (status, position, count). A transfer happens when valid and ready are both high.
// The result is registered after a parallel compare across all cells and then an
// update; one item is in flight at a time, so the block takes no new item until
// the capture/compare/update sequence of the last one is through.
// The result sits in an output register, so a finished result may wait while the
// next item is already being taken in; if the receiver still stalls when the next
// update is due, the controller holds in its update step and i_in.ready stays low.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending result;
// the entry cells themselves are not cleared and are never read past the count.
// Status: ok, full on insert, empty on remove, not found on remove. Position is the
// placement/removal index or the lower bound for a query; count is after the item.
// depends on sle_pkg, sle_if, sle_ctrl, sle_dp

module sorted_list_engine_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sle_in_if.sink     i_in,
    sle_out_if.source  o_out
);
    import sle_pkg::*;

    t_dp_cmd cmd;

    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    sle_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_operation (i_in.operation),
        .i_value     (i_in.value),
        .o_status    (o_out.status),
        .o_position  (o_out.position),
        .o_count     (o_out.count)
    );

endmodule
